// ===== rtl/dfq_pkg.sv =====
package dfq_pkg;

  // Opcodes of an input item
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_REMOVED = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] value;
  } dfq_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         occupancy;
  } dfq_out_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } dfq_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch item and register the membership compare
    logic commit;   // update queue state and load the result register
  } dfq_cmd_t;

endpackage

// ===== rtl/dfq_ctrl.sv =====
module dfq_ctrl import dfq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dfq_cmd_t cmd_o
);

  dfq_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    out_valid_d   = out_valid_q;
    // drop the result once it is taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // commit only when the result register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/dfq_datapath.sv =====
module dfq_datapath import dfq_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dfq_cmd_t cmd_i,
  input  dfq_in_t  in_item_i,
  output dfq_out_t out_item_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [VALUE_WIDTH-1:0] entries_q [DEPTH];
  logic [PtrW-1:0]        rd_q, rd_d, wr_q, wr_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   opcode_q;
  logic [VALUE_WIDTH-1:0] value_q, value_in;
  logic [DEPTH-1:0]       match_q, match_d;
  dfq_out_t               res_q, res_d;
  logic                   write_en;
  logic [63:0]            in_wide, rd_wide;

  // Store values in their low VALUE_WIDTH bits
  assign in_wide  = {32'b0, in_item_i.value};
  assign value_in = in_wide[VALUE_WIDTH-1:0];

  // Compare the incoming value with every occupied entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    logic [PtrW:0] offset;
    logic          occupied;
    always_comb begin
      if ((PtrW + 1)'(i) >= {1'b0, rd_q}) begin
        offset = (PtrW + 1)'(i) - {1'b0, rd_q};
      end else begin
        offset = (PtrW + 1)'(i) + (PtrW + 1)'(DEPTH) - {1'b0, rd_q};
      end
      occupied   = offset < (PtrW + 1)'(count_q);
      match_d[i] = occupied && (entries_q[i] == value_in);
    end
  end

  // Hold the item and its match vector for the commit cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      opcode_q <= in_item_i.opcode;
      value_q  <= value_in;
      match_q  <= match_d;
    end
  end

  // Decide the outcome and the next queue state
  assign rd_wide = 64'(entries_q[rd_q]);

  always_comb begin
    rd_d     = rd_q;
    wr_d     = wr_q;
    count_d  = count_q;
    write_en = 1'b0;
    res_d.removed_value = '0;
    if (opcode_q == OP_ADD) begin
      priority if (|match_q) begin
        res_d.status = ST_DUP;
      end else if (count_q == CntW'(DEPTH)) begin
        res_d.status = ST_FULL;
      end else begin
        res_d.status = ST_ADDED;
        write_en     = 1'b1;
        wr_d         = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
        count_d      = count_q + 1'b1;
      end
    end else begin
      priority if (count_q == '0) begin
        res_d.status = ST_EMPTY;
      end else begin
        res_d.status        = ST_REMOVED;
        res_d.removed_value = rd_wide[31:0];
        rd_d                = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
        count_d             = count_q - 1'b1;
      end
    end
    res_d.occupancy = 5'(count_d);
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      wr_q    <= '0;
      count_q <= '0;
    end else if (cmd_i.commit) begin
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      count_q <= count_d;
    end
  end

  // Append at the tail and load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && write_en) begin
      entries_q[wr_q] <= value_q;
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  assign out_item_o = res_q;

endmodule

// ===== rtl/dedup_fifo_queue_unit.sv =====
// Channel | Handshake                  | Payload
// --------+----------------------------+------------------------------------------
// in      | in_valid_i / in_ready_o    | in_item_i  : opcode, value
// out     | out_valid_o / out_ready_i  | out_item_o : status, removed_value, occupancy
//
// Each item is accepted in S_IDLE, which registers the compare of the value against
// all DEPTH entries; S_COMMIT then reduces it and updates the ring.
// The next item is accepted while the previous result waits in the output register;
// a stalled output holds the commit cycle until the result register frees up.
// Reset empties the queue (pointers and count to zero); entries are not cleared.
module dedup_fifo_queue_unit import dfq_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dfq_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dfq_out_t out_item_o
);

  dfq_cmd_t cmd;

  dfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  dfq_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule
